### hw/rtl/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// Command codes and fixed port widths shared by the edit distance engine.
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam int SYMBOL_IN_BITS = 8;
  localparam int DIST_BITS      = 7;
  localparam int CMD_BITS       = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_COMPUTE       = 2'd2
  } cmd_t;

endpackage

### hw/rtl/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein distance of two loaded symbol strings, one row of costs kept in
// a memory, swept by a shared cost unit one cell per cycle after each row setup.
//
//   channel   handshake          fields
//   command   start / busy       command, symbol
//   result    done (strobe)      distance, overflowed
//
// a load beat leaves busy low
// compute with both strings non-empty: busy, per row, through a setup state
// for the row memory read and then one cell per cycle through the cost unit;
// done in the cycle after the last cell; an empty string gives done at once
// rst is synchronous and clears lengths, overflow flag and sequencer
// the result is shown for one cycle with done; the receiver cannot stall
// ----------------------------------------------------------------------------
module edit_distance_engine
  import edc_pkg::*;
#(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [CMD_BITS-1:0]       command,
  input  logic [SYMBOL_IN_BITS-1:0] symbol,
  output logic                      busy,
  output logic                      done,
  output logic [DIST_BITS-1:0]      distance,
  output logic                      overflowed
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SB = (SYMBOL_BITS < SYMBOL_IN_BITS) ? SYMBOL_BITS : SYMBOL_IN_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CELL
  } state_t;

  state_t        state;
  logic [LW-1:0] first_len;
  logic [LW-1:0] second_len;
  logic          overflow_seen;
  logic [LW-1:0] row_i;
  logic [LW-1:0] col_j;
  logic [LW-1:0] diag;
  logic [LW-1:0] left;

  logic [SB-1:0] first_mem  [MAX_LEN];
  logic [SB-1:0] second_mem [MAX_LEN];
  logic [LW-1:0] row_mem    [MAX_LEN+1];

  logic [SB-1:0] first_rdata;
  logic [SB-1:0] second_rdata;
  logic [LW-1:0] row_rdata;

  logic [LW-1:0] first_raddr_full;
  logic [AW-1:0] first_raddr;
  logic [AW-1:0] second_raddr;
  logic [LW-1:0] row_raddr;
  logic [LW-1:0] above;
  logic [LW-1:0] cost;
  logic [SB-1:0] sym_in;
  logic          load_first;
  logic          load_second;
  logic          cmd_beat;

  assign busy        = (state != ST_IDLE);
  assign cmd_beat    = start && !busy;
  assign sym_in      = symbol[SB-1:0];
  assign load_first  = cmd_beat && (command == CMD_APPEND_FIRST) &&
                       (first_len < LW'(MAX_LEN));
  assign load_second = cmd_beat && (command == CMD_APPEND_SECOND) &&
                       (second_len < LW'(MAX_LEN));

  always_comb begin
    first_raddr_full = row_i - LW'(1);
    first_raddr      = first_raddr_full[AW-1:0];
    if (state == ST_SETUP) begin
      second_raddr = '0;
      row_raddr    = LW'(1);
    end else begin
      second_raddr = col_j[AW-1:0];
      row_raddr    = col_j + LW'(1);
    end
    // first row reads the implicit base row 0..n
    above = (row_i == LW'(1)) ? col_j : row_rdata;
  end

  // symbol stores
  always_ff @(posedge clk) begin
    if (load_first) begin
      first_mem[first_len[AW-1:0]] <= sym_in;
    end
    if (load_second) begin
      second_mem[second_len[AW-1:0]] <= sym_in;
    end
    first_rdata  <= first_mem[first_raddr];
    second_rdata <= second_mem[second_raddr];
  end

  // cost row
  always_ff @(posedge clk) begin
    if (state == ST_CELL) begin
      row_mem[col_j] <= cost;
    end
    row_rdata <= row_mem[row_raddr];
  end

  edc_cell_unit #(
    .CW (LW),
    .SB (SB)
  ) u_cell (
    .sym_a (first_rdata),
    .sym_b (second_rdata),
    .above (above),
    .left  (left),
    .diag  (diag),
    .cost  (cost)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_len     <= '0;
      second_len    <= '0;
      overflow_seen <= 1'b0;
      row_i         <= '0;
      col_j         <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            case (command)
              CMD_APPEND_FIRST: begin
                if (first_len < LW'(MAX_LEN)) begin
                  first_len <= first_len + LW'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              CMD_APPEND_SECOND: begin
                if (second_len < LW'(MAX_LEN)) begin
                  second_len <= second_len + LW'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              CMD_COMPUTE: begin
                if (first_len == '0 || second_len == '0) begin
                  done          <= 1'b1;
                  distance      <= DIST_BITS'((first_len == '0) ? second_len : first_len);
                  overflowed    <= overflow_seen;
                  first_len     <= '0;
                  second_len    <= '0;
                  overflow_seen <= 1'b0;
                end else begin
                  row_i <= LW'(1);
                  state <= ST_SETUP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SETUP: begin
          diag  <= row_i - LW'(1);
          left  <= row_i;
          col_j <= LW'(1);
          state <= ST_CELL;
        end
        ST_CELL: begin
          left <= cost;
          diag <= above;
          if (col_j == second_len) begin
            if (row_i == first_len) begin
              done          <= 1'b1;
              distance      <= DIST_BITS'(cost);
              overflowed    <= overflow_seen;
              first_len     <= '0;
              second_len    <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              row_i <= row_i + LW'(1);
              state <= ST_SETUP;
            end
          end else begin
            col_j <= col_j + LW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/edc_cell_unit.sv
// ----------------------------------------------------------------------------
// edc_cell_unit
// Shared cost unit: one symbol compare, a three-way minimum and an increment.
// ----------------------------------------------------------------------------
module edc_cell_unit #(
  parameter int CW = 7,
  parameter int SB = 8
) (
  input  logic [SB-1:0] sym_a,
  input  logic [SB-1:0] sym_b,
  input  logic [CW-1:0] above,
  input  logic [CW-1:0] left,
  input  logic [CW-1:0] diag,
  output logic [CW-1:0] cost
);

  logic [CW-1:0] min_ab;
  logic [CW-1:0] min_all;

  always_comb begin
    min_ab  = (above < left) ? above : left;
    min_all = (min_ab < diag) ? min_ab : diag;
    if (sym_a == sym_b) begin
      cost = diag;
    end else begin
      cost = min_all + CW'(1);
    end
  end

endmodule

### hw/rtl/edc_checker.sv
// ----------------------------------------------------------------------------
// edc_checker
// Port-level checks on command beats, busy and the result strobe.
// ----------------------------------------------------------------------------
module edc_checker
  import edc_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic [CMD_BITS-1:0]  command,
  input logic                 busy,
  input logic                 done,
  input logic [DIST_BITS-1:0] distance
);

  logic cmd_beat;
  assign cmd_beat = start && !busy;

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    cmd_beat && command != CMD_COMPUTE |=> !done)
    else $error("result after a load beat");

  a_compute_reacts: assert property (@(posedge clk) disable iff (rst)
    cmd_beat && command == CMD_COMPUTE |=> busy || done)
    else $error("compute beat ignored");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_busy_from_compute: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && command == CMD_COMPUTE))
    else $error("busy raised without a compute beat");

  a_distance_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(distance) <= MAX_LEN)
    else $error("distance above string limit");

endmodule

bind edit_distance_engine edc_checker #(
  .MAX_LEN (MAX_LEN)
) u_edc_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .command  (command),
  .busy     (busy),
  .done     (done),
  .distance (distance)
);

### sim/edit_distance_checker.sv
// ----------------------------------------------------------------------------
// edit_distance_checker
// Watches the command and result channels of the edit distance engine. Each
// accepted append beat fills a private string copy; a compute beat queues
// the Levenshtein distance and the overflow flag expected back. Each done
// strobe is compared field by field with the oldest queued answer.
// ----------------------------------------------------------------------------
module edit_distance_checker
  import edc_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [CMD_BITS-1:0]       command,
  input  logic [SYMBOL_IN_BITS-1:0] symbol,
  input  logic                      done,
  input  logic [DIST_BITS-1:0]      distance,
  input  logic                      overflowed,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 overflowed;
  } answer_t;

  answer_t                   answers_due[$];
  logic [SYMBOL_IN_BITS-1:0] first_str [MAX_LEN];
  logic [SYMBOL_IN_BITS-1:0] second_str [MAX_LEN];
  int                        first_len;
  int                        second_len;
  bit                        dropped_symbol;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // single cost row swept over the first string
  function automatic int levenshtein();
    int row [MAX_LEN+1];
    int diag;
    int above;
    int best;
    for (int j = 0; j <= second_len; j++) row[j] = j;
    for (int i = 1; i <= first_len; i++) begin
      diag   = row[0];
      row[0] = i;
      for (int j = 1; j <= second_len; j++) begin
        above = row[j];
        if (first_str[i-1] == second_str[j-1]) begin
          row[j] = diag;
        end else begin
          best = above < row[j-1] ? above : row[j-1];
          best = best < diag ? best : diag;
          row[j] = best + 1;
        end
        diag = above;
      end
    end
    return row[second_len];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) $display("checker: mismatch: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      first_len      = 0;
      second_len     = 0;
      dropped_symbol = 1'b0;
      answers_due.delete();
    end else begin
      if (done !== 1'b0) begin
        if (done !== 1'b1) begin
          report_mismatch("done strobe is unknown");
        end else if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: distance %0d", distance));
        end else begin
          want = answers_due.pop_front();
          if (distance !== want.distance)
            report_mismatch($sformatf("distance got %0d expected %0d", distance,
                                      want.distance));
          if (overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %0b expected %0b", overflowed,
                                      want.overflowed));
        end
      end
      if (start && !busy) begin
        case (command)
          CMD_APPEND_FIRST: begin
            if (first_len < MAX_LEN) begin
              first_str[first_len] = symbol;
              first_len++;
            end else begin
              dropped_symbol = 1'b1;
            end
          end
          CMD_APPEND_SECOND: begin
            if (second_len < MAX_LEN) begin
              second_str[second_len] = symbol;
              second_len++;
            end else begin
              dropped_symbol = 1'b1;
            end
          end
          CMD_COMPUTE: begin
            want.distance   = DIST_BITS'(levenshtein());
            want.overflowed = dropped_symbol;
            answers_due.push_back(want);
            first_len      = 0;
            second_len     = 0;
            dropped_symbol = 1'b0;
          end
          default: ;
        endcase
      end
    end
    outstanding = answers_due.size();
  end

endmodule

### sim/edit_distance_engine_tb.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_tb
// Drives string pairs into the edit distance engine: a short directed set
// (empty strings, extreme symbols, the unused command) followed by random
// pairs of mostly short strings over small alphabets, some long ones and some
// that overfill a string. Random gaps between command beats; the checker
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module edit_distance_engine_tb;
  import edc_pkg::*;

  localparam int                  MAX_LEN       = 64;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED    = 2'd3;
  localparam int                  BEAT_TARGET   = 1400;
  localparam int                  SETTLE_CYCLES = 40;
  localparam int                  CYCLE_LIMIT   = 2000000;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic [CMD_BITS-1:0]       command;
  logic [SYMBOL_IN_BITS-1:0] symbol;
  logic                      busy;
  logic                      done;
  logic [DIST_BITS-1:0]      distance;
  logic                      overflowed;
  int                        mismatches;
  int                        outstanding;
  int                        cycles = 0;
  int                        beats_sent = 0;
  bit                        burst = 1'b0;

  edit_distance_engine #(
    .MAX_LEN    (MAX_LEN),
    .SYMBOL_BITS(8)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .symbol    (symbol),
    .busy      (busy),
    .done      (done),
    .distance  (distance),
    .overflowed(overflowed)
  );

  edit_distance_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .symbol     (symbol),
    .done       (done),
    .distance   (distance),
    .overflowed (overflowed),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int pick_span();
    case ($urandom_range(0, 3))
      0: return 1;
      1: return 2;
      2: return 4;
      default: return 256;
    endcase
  endfunction

  task automatic issue(input logic [CMD_BITS-1:0] cmd, input logic [7:0] sym);
    int gap;
    start   <= 1'b1;
    command <= cmd;
    symbol  <= sym;
    do @(posedge clk); while (busy !== 1'b0);
    if (cmd != CMD_UNUSED) beats_sent++;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      start   <= 1'b0;
      command <= CMD_BITS'($urandom);
      symbol  <= SYMBOL_IN_BITS'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // loads of the two strings interleaved at random with occasional unused commands, then compute
  task automatic load_pair(input int na, input int nb, input int span);
    int ia;
    int ib;
    int base;
    ia   = 0;
    ib   = 0;
    base = (span == 256) ? 0 : $urandom_range(0, 256 - span);
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 19) == 0) begin
        issue(CMD_UNUSED, 8'($urandom));
      end else if (ib >= nb || (ia < na && $urandom_range(0, 1))) begin
        issue(CMD_APPEND_FIRST, 8'(base + $urandom_range(0, span - 1)));
        ia++;
      end else begin
        issue(CMD_APPEND_SECOND, 8'(base + $urandom_range(0, span - 1)));
        ib++;
      end
    end
    issue(CMD_COMPUTE, 8'($urandom));
  endtask

  initial begin
    int r;
    rst     = 1'b1;
    start   = 1'b0;
    command = CMD_APPEND_FIRST;
    symbol  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // both strings empty, then one symbol each
    issue(CMD_COMPUTE, 8'h00);
    issue(CMD_APPEND_FIRST, 8'h00);
    issue(CMD_APPEND_SECOND, 8'hFF);
    issue(CMD_COMPUTE, 8'hFF);
    // first string empty, unused command in between
    issue(CMD_APPEND_SECOND, 8'h55);
    issue(CMD_UNUSED, 8'hFF);
    issue(CMD_APPEND_SECOND, 8'hAA);
    issue(CMD_COMPUTE, 8'h00);
    // second string empty
    issue(CMD_APPEND_FIRST, 8'h80);
    issue(CMD_APPEND_FIRST, 8'h01);
    issue(CMD_APPEND_FIRST, 8'h7F);
    issue(CMD_COMPUTE, 8'h00);
    // identical strings
    issue(CMD_APPEND_FIRST, 8'hFF);
    issue(CMD_APPEND_SECOND, 8'hFF);
    issue(CMD_APPEND_FIRST, 8'h00);
    issue(CMD_APPEND_SECOND, 8'h00);
    issue(CMD_UNUSED, 8'h00);
    issue(CMD_COMPUTE, 8'hFF);

    while (beats_sent < BEAT_TARGET) begin
      burst = ($urandom_range(0, 4) == 0);
      r     = $urandom_range(0, 99);
      if (r < 84) begin
        load_pair($urandom_range(0, 10), $urandom_range(0, 10), pick_span());
      end else if (r < 92) begin
        load_pair($urandom_range(40, MAX_LEN), $urandom_range(40, MAX_LEN), pick_span());
      end else if (r < 96) begin
        load_pair($urandom_range(MAX_LEN + 1, MAX_LEN + 6), $urandom_range(0, 12),
                  pick_span());
      end else if (r < 98) begin
        load_pair($urandom_range(0, 12), $urandom_range(MAX_LEN + 1, MAX_LEN + 6),
                  pick_span());
      end else begin
        load_pair(MAX_LEN, MAX_LEN, pick_span());
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/edc_pkg.sv
hw/rtl/edc_cell_unit.sv
hw/rtl/edit_distance_engine.sv
hw/rtl/edc_checker.sv
sim/edit_distance_checker.sv
sim/edit_distance_engine_tb.sv
